FILE: rtl/core/gmt_pkg.sv
package gmt_pkg;

   localparam int MAX_GROUPS  = 16;
   localparam int MAX_MEMBERS = 16;

   localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);
   localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int NW = $clog2(MAX_MEMBERS + 1);
   localparam int RAM_DEPTH = MAX_GROUPS * (2 ** MW);

   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_ADD    = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_LIST   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic [1:0] SLOP_NONE   = 2'd0;
   localparam logic [1:0] SLOP_CREATE = 2'd1;
   localparam logic [1:0] SLOP_DELETE = 2'd2;
   localparam logic [1:0] SLOP_SETMC  = 2'd3;

   typedef struct packed {
      logic [1:0]    op;
      logic [GW-1:0] gid;
      logic [NW-1:0] mc;
   } slot_cmd_type;

endpackage

FILE: rtl/core/gmt_ram.sv
module gmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/gmt_slots.sv
module gmt_slots (
   input  logic                 clock,
   input  logic                 reset,
   input  gmt_pkg::slot_cmd_type cmd,
   input  logic [gmt_pkg::GW-1:0] rd_idx,
   output logic [gmt_pkg::GW-1:0] rd_gid,
   output logic [gmt_pkg::NW-1:0] rd_mc,
   output logic [gmt_pkg::GW-1:0] rd_row,
   output logic [gmt_pkg::CW-1:0] count
);
   import gmt_pkg::*;

   logic [GW-1:0] gid_ff [MAX_GROUPS];
   logic [NW-1:0] mc_ff  [MAX_GROUPS];
   logic [GW-1:0] row_ff [MAX_GROUPS];
   logic [CW-1:0] count_ff;
   logic [GW-1:0] top_idx;

   assign rd_gid  = gid_ff[rd_idx];
   assign rd_mc   = mc_ff[rd_idx];
   assign rd_row  = row_ff[rd_idx];
   assign count   = count_ff;
   assign top_idx = GW'(count_ff - CW'(1));

   // Deleting a slot shifts the later slots down; the freed memory row moves
   // to the last used position so the rows stay a permutation.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int j = 0; j < MAX_GROUPS; j++) begin
            row_ff[j] <= GW'(j);
         end
      end else begin
         case (cmd.op)
            SLOP_CREATE: begin
               count_ff <= count_ff + CW'(1);
            end
            SLOP_DELETE: begin
               count_ff <= count_ff - CW'(1);
               for (int j = 0; j < MAX_GROUPS; j++) begin
                  if (GW'(j) == top_idx) begin
                     row_ff[j] <= row_ff[rd_idx];
                  end else if (GW'(j) >= rd_idx && GW'(j) < top_idx &&
                               j < MAX_GROUPS - 1) begin
                     row_ff[j] <= row_ff[j + 1];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         SLOP_CREATE: begin
            gid_ff[count_ff[GW-1:0]] <= cmd.gid;
            mc_ff[count_ff[GW-1:0]]  <= '0;
         end
         SLOP_DELETE: begin
            for (int j = 0; j < MAX_GROUPS - 1; j++) begin
               if (GW'(j) >= rd_idx) begin
                  gid_ff[j] <= gid_ff[j + 1];
                  mc_ff[j]  <= mc_ff[j + 1];
               end
            end
         end
         SLOP_SETMC: begin
            mc_ff[rd_idx] <= cmd.mc;
         end
         default: begin
         end
      endcase
   end
endmodule

FILE: rtl/core/group_membership_table.sv
// Channel  | Ports                                      | Direction
// request  | req_valid, req_stall, req_command/group/member_addr | in
// response | rsp_valid, rsp_stall, rsp_status/result_group/listed_addr/last | out
//
// One command at a time; req_stall is high from acceptance until its last word
// has been loaded into the output register. A command walks the slots in order
// to find its group (on create, the ids from 0 to the lowest free one), then
// scans members on add/remove, shifts later ones down on remove, or lists each.
// After reset the table is empty and the block is ready at once. A stalled
// response holds its word.
module group_membership_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_group,
   input  logic [15:0] req_member_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_result_group,
   output logic [15:0] rsp_listed_addr,
   output logic        rsp_last
);
   import gmt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_NEWID    = 4'd2;
   localparam logic [3:0] S_FIND     = 4'd3;
   localparam logic [3:0] S_SCAN_RD  = 4'd4;
   localparam logic [3:0] S_SCAN_CMP = 4'd5;
   localparam logic [3:0] S_SHIFT_RD = 4'd6;
   localparam logic [3:0] S_SHIFT_WR = 4'd7;
   localparam logic [3:0] S_LIST_RD  = 4'd8;
   localparam logic [3:0] S_LIST_OUT = 4'd9;
   localparam logic [3:0] S_REPLY    = 4'd10;

   localparam int AW = $clog2(RAM_DEPTH);

   logic [3:0]            state_ff, state_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [7:0]            gid_ff, gid_in;
   logic [15:0]           addr_ff, addr_in;
   logic [NW-1:0]         idx_ff, idx_in;
   logic [GW-1:0]         slot_ff, slot_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [MAX_GROUPS-1:0] used_ff, used_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [7:0]            res_group_ff, res_group_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [7:0]            rsp_group_ff, rsp_group_in;
   logic [15:0]           rsp_addr_ff, rsp_addr_in;
   logic                  rsp_last_ff, rsp_last_in;

   slot_cmd_type  slot_cmd;
   logic [GW-1:0] rd_idx, rd_gid, rd_row;
   logic [NW-1:0] rd_mc;
   logic [CW-1:0] count;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic [15:0]   cmp_a, cmp_b;
   logic          cmp_eq, out_free;

   assign rd_idx = (state_ff == S_FIND) ? idx_ff[GW-1:0] : slot_ff;

   gmt_slots u_slots (
      .clock  (clock),
      .reset  (reset),
      .cmd    (slot_cmd),
      .rd_idx (rd_idx),
      .rd_gid (rd_gid),
      .rd_mc  (rd_mc),
      .rd_row (rd_row),
      .count  (count)
   );

   assign rd_addr = AW'({rd_row, idx_ff[MW-1:0]});

   gmt_ram #(.WIDTH(16), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The single equality unit serves both the group search and member scans.
   assign cmp_a  = (state_ff == S_FIND) ? {8'd0, gid_ff} : rd_data;
   assign cmp_b  = (state_ff == S_FIND) ? 16'(rd_gid) : addr_ff;
   assign cmp_eq = (cmp_a == cmp_b);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_group = rsp_group_ff;
   assign rsp_listed_addr  = rsp_addr_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      gid_in        = gid_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      n_in          = n_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_group_in  = res_group_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_group_in  = rsp_group_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_last_in   = rsp_last_ff;
      slot_cmd      = '{op: SLOP_NONE, gid: '0, mc: '0};
      wr_en         = 1'b0;
      wr_addr       = AW'({rd_row, n_ff[MW-1:0]});
      wr_data       = addr_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               gid_in   = req_group;
               addr_in  = req_member_addr;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            idx_in       = '0;
            res_group_in = gid_ff;
            if (cmd_ff == CMD_CREATE) begin
               if (count >= CW'(MAX_GROUPS)) begin
                  res_status_in = ST_FULL;
                  res_group_in  = '0;
                  state_in      = S_REPLY;
               end else begin
                  state_in = S_NEWID;
               end
            end else if (cmd_ff > CMD_LIST) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_REPLY;
            end else begin
               state_in = S_FIND;
            end
         end
         S_NEWID: begin
            if (!used_ff[idx_ff[GW-1:0]]) begin
               slot_cmd.op                = SLOP_CREATE;
               slot_cmd.gid               = idx_ff[GW-1:0];
               used_in[idx_ff[GW-1:0]]    = 1'b1;
               res_status_in              = ST_OK;
               res_group_in               = 8'(idx_ff[GW-1:0]);
               state_in                   = S_REPLY;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         S_FIND: begin
            if (CW'(idx_ff) >= count) begin
               res_status_in = ST_NOTFOUND;
               state_in      = S_REPLY;
            end else if (cmp_eq) begin
               slot_in = idx_ff[GW-1:0];
               n_in    = rd_mc;
               idx_in  = '0;
               case (cmd_ff)
                  CMD_DELETE: begin
                     slot_cmd.op     = SLOP_DELETE;
                     used_in[rd_gid] = 1'b0;
                     res_status_in   = ST_OK;
                     state_in        = S_REPLY;
                  end
                  CMD_LIST: begin
                     if (rd_mc == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_REPLY;
                     end else begin
                        state_in = S_LIST_RD;
                     end
                  end
                  default: begin
                     state_in = S_SCAN_RD;
                  end
               endcase
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == n_ff) begin
               if (cmd_ff == CMD_REMOVE) begin
                  res_status_in = ST_NOTFOUND;
               end else if (n_ff >= NW'(MAX_MEMBERS)) begin
                  res_status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  slot_cmd.op   = SLOP_SETMC;
                  slot_cmd.mc   = n_ff + NW'(1);
                  res_status_in = ST_OK;
               end
               state_in = S_REPLY;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            idx_in = idx_ff + NW'(1);
            if (cmp_eq) begin
               if (cmd_ff == CMD_REMOVE) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  res_status_in = ST_OK;
                  state_in      = S_REPLY;
               end
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == n_ff) begin
               slot_cmd.op   = SLOP_SETMC;
               slot_cmd.mc   = n_ff - NW'(1);
               res_status_in = ST_OK;
               state_in      = S_REPLY;
            end else begin
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'({rd_row, MW'(idx_ff - NW'(1))});
            wr_data  = rd_data;
            idx_in   = idx_ff + NW'(1);
            state_in = S_SHIFT_RD;
         end
         S_LIST_RD: begin
            state_in = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_group_in  = gid_ff;
               rsp_addr_in   = rd_data;
               rsp_last_in   = (idx_ff + NW'(1) == n_ff);
               idx_in        = idx_ff + NW'(1);
               state_in      = (idx_ff + NW'(1) == n_ff) ? S_IDLE : S_LIST_RD;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_group_in  = res_group_ff;
               rsp_addr_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      gid_ff        <= gid_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_group_ff  <= res_group_in;
      rsp_status_ff <= rsp_status_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_last_ff   <= rsp_last_in;
   end
endmodule

FILE: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gmt_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  group;
      logic [15:0] addr;
      logic        last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = '0;
   logic [7:0]  req_group = '0;
   logic [15:0] req_member_addr = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_result_group;
   logic [15:0] rsp_listed_addr;
   logic        rsp_last;

   group_membership_table dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the table.
   int          tbl_count;
   int          tbl_gid [MAX_GROUPS];
   int          tbl_n [MAX_GROUPS];
   logic [15:0] tbl_mem [MAX_GROUPS][MAX_MEMBERS];

   word_type    pending_words[$];
   int          errors = 0;
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int          rx_hold = 0;
   int          rx_burst = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic int lookup_slot(input int gid);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_gid[i] == gid) return i;
      return MAX_GROUPS;
   endfunction

   function automatic void push_word(input logic [1:0] st, input int grp,
                                     input int addr, input bit lst);
      word_type w;
      w.status = st;
      w.group  = grp[7:0];
      w.addr   = addr[15:0];
      w.last   = lst;
      pending_words.push_back(w);
   endfunction

   function automatic void predict_command(input logic [2:0] cmd, input logic [7:0] gid,
                                           input logic [15:0] addr);
      int s, n, id, pos;
      bit used;
      if (cmd == CMD_CREATE) begin
         if (tbl_count >= MAX_GROUPS) begin
            push_word(ST_FULL, 0, 0, 1);
            return;
         end
         for (id = 0; id < MAX_GROUPS; id++) begin
            used = 0;
            for (int j = 0; j < tbl_count; j++)
               if (tbl_gid[j] == id) used = 1;
            if (!used) break;
         end
         tbl_gid[tbl_count] = id;
         tbl_n[tbl_count] = 0;
         tbl_count++;
         push_word(ST_OK, id, 0, 1);
         return;
      end
      if (cmd > CMD_LIST) begin
         push_word(ST_NOTFOUND, gid, 0, 1);
         return;
      end
      s = lookup_slot(gid);
      if (s >= MAX_GROUPS) begin
         push_word(ST_NOTFOUND, gid, 0, 1);
         return;
      end
      n = tbl_n[s];
      case (cmd)
         CMD_DELETE: begin
            for (int i = s; i + 1 < tbl_count; i++) begin
               tbl_gid[i] = tbl_gid[i+1];
               tbl_n[i] = tbl_n[i+1];
               tbl_mem[i] = tbl_mem[i+1];
            end
            tbl_count--;
            push_word(ST_OK, gid, 0, 1);
         end
         CMD_ADD: begin
            for (int i = 0; i < n; i++)
               if (tbl_mem[s][i] == addr) begin
                  push_word(ST_OK, gid, 0, 1);
                  return;
               end
            if (n >= MAX_MEMBERS) begin
               push_word(ST_FULL, gid, 0, 1);
               return;
            end
            tbl_mem[s][n] = addr;
            tbl_n[s] = n + 1;
            push_word(ST_OK, gid, 0, 1);
         end
         CMD_REMOVE: begin
            pos = n;
            for (int i = n - 1; i >= 0; i--)
               if (tbl_mem[s][i] == addr) pos = i;
            if (pos >= n) begin
               push_word(ST_NOTFOUND, gid, 0, 1);
               return;
            end
            for (int i = pos; i + 1 < n; i++)
               tbl_mem[s][i] = tbl_mem[s][i+1];
            tbl_n[s] = n - 1;
            push_word(ST_OK, gid, 0, 1);
         end
         default: begin
            if (n == 0) push_word(ST_EMPTY, gid, 0, 1);
            else
               for (int i = 0; i < n; i++)
                  push_word(ST_OK, gid, tbl_mem[s][i], i + 1 == n);
         end
      endcase
   endfunction

   // Offers one word and waits until it is accepted; may idle afterward.
   task automatic send_command(input logic [2:0] cmd, input logic [7:0] gid,
                               input logic [15:0] addr);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_group       <= gid;
      req_member_addr <= addr;
      do @(posedge clock); while (req_stall);
      predict_command(cmd, gid, addr);
      @(negedge clock);
      req_valid <= 1'b0;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_result_group, 0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_result_group !== want.group)
               report_mismatch("result_group", rsp_result_group, want.group);
            if (rsp_listed_addr !== want.addr)
               report_mismatch("listed_addr", rsp_listed_addr, want.addr);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Receiver: a long hold-off when requested, otherwise random stall bursts.
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold <= rx_hold - 1;
      end else if (rx_burst > 0) begin
         rsp_stall <= 1'b1;
         rx_burst <= rx_burst - 1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         rx_burst <= $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_directed();
      send_command(CMD_LIST, 8'd0, 16'h0000);
      send_command(CMD_DELETE, 8'hFF, 16'h0000);
      send_command(CMD_CREATE, 8'hFF, 16'hFFFF);
      send_command(CMD_LIST, 8'd0, 16'h0000);
      send_command(CMD_ADD, 8'd0, 16'h0000);
      send_command(CMD_ADD, 8'd0, 16'hFFFF);
      send_command(CMD_ADD, 8'd0, 16'hFFFF);
      send_command(CMD_LIST, 8'd0, 16'h0000);
      send_command(CMD_REMOVE, 8'd0, 16'h1234);
      send_command(CMD_REMOVE, 8'd0, 16'h0000);
      send_command(CMD_ADD, 8'd7, 16'h0001);
      send_command(3'd5, 8'd0, 16'h0000);
      send_command(3'd6, 8'hAA, 16'h5555);
      send_command(3'd7, 8'h55, 16'hAAAA);
      send_command(CMD_LIST, 8'd0, 16'h0000);
      send_command(CMD_DELETE, 8'd0, 16'h0000);
      send_command(CMD_LIST, 8'd0, 16'h0000);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < MAX_GROUPS + 1; i++)
         send_command(CMD_CREATE, 8'd0, 16'h0000);
      for (int i = 0; i < MAX_MEMBERS + 1; i++)
         send_command(CMD_ADD, 8'd15, 16'(16'h0100 + i));
      send_command(CMD_ADD, 8'd15, 16'h0103);
      send_command(CMD_LIST, 8'd15, 16'h0000);
      send_command(CMD_DELETE, 8'd3, 16'h0000);
      send_command(CMD_CREATE, 8'd0, 16'h0000);
   endtask

   task automatic random_command();
      logic [2:0]  cmd;
      logic [7:0]  gid;
      logic [15:0] addr;
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) cmd = CMD_CREATE;
      else if (r < 16) cmd = CMD_DELETE;
      else if (r < 55) cmd = CMD_ADD;
      else if (r < 75) cmd = CMD_REMOVE;
      else if (r < 95) cmd = CMD_LIST;
      else cmd = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) gid = 8'($urandom_range(0, 255));
      else if (tbl_count > 0 && $urandom_range(0, 3) != 0)
         gid = 8'(tbl_gid[$urandom_range(0, tbl_count - 1)]);
      else gid = 8'($urandom_range(0, MAX_GROUPS + 1));
      if ($urandom_range(0, 2) == 0) addr = 16'($urandom);
      else addr = 16'($urandom_range(0, 23)) ^ {16{gid[0]}};
      send_command(cmd, gid, addr);
   endtask

   task automatic test_random(input int count);
      repeat (count) random_command();
   endtask

   task automatic test_backpressure();
      rx_hold = 300;
      repeat (6) random_command();
      wait_drained();
      repeat (5) random_command();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random(170);
      test_backpressure();
      test_random(120);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random(60);
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0 && pending_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/gmt_pkg.sv
rtl/core/gmt_ram.sv
rtl/core/gmt_slots.sv
rtl/core/group_membership_table.sv
sim/testbench.sv
